### rtl/pdpc_pkg.sv
// Shared types, constants and arithmetic for the angular PDPC row blend.
`default_nettype none
package pdpc_pkg;

	// Reference depth must be a multiple of NBANK (powers of two in range are).
	localparam int REF_DEPTH_DEF = 512;
	localparam int LANES_DEF     = 8;
	localparam int NBANK         = 8;

	localparam logic [6:0] HEIGHT_RST = 7'd4;

	typedef enum logic [1:0] {
		CFG_ANGLE  = 2'd0,
		CFG_SCALE  = 2'd1,
		CFG_HEIGHT = 2'd2,
		CFG_WIDE   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic       corr;
		logic [2:0] shift;
		logic       last;
		logic [2:0] rot;
	} ctrl_t;

	function automatic logic [14:0] inv_angle(input logic [4:0] idx);
		logic [14:0] v;
		unique case (idx)
			5'd0:  v = 15'd0;
			5'd1:  v = 15'd16384;
			5'd2:  v = 15'd8192;
			5'd3:  v = 15'd5461;
			5'd4:  v = 15'd4096;
			5'd5:  v = 15'd2731;
			5'd6:  v = 15'd2048;
			5'd7:  v = 15'd1638;
			5'd8:  v = 15'd1365;
			5'd9:  v = 15'd1170;
			5'd10: v = 15'd1024;
			5'd11: v = 15'd910;
			5'd12: v = 15'd819;
			5'd13: v = 15'd712;
			5'd14: v = 15'd630;
			5'd15: v = 15'd565;
			5'd16: v = 15'd512;
			5'd17: v = 15'd468;
			5'd18: v = 15'd420;
			5'd19: v = 15'd364;
			5'd20: v = 15'd321;
			5'd21: v = 15'd287;
			5'd22: v = 15'd256;
			5'd23: v = 15'd224;
			5'd24: v = 15'd191;
			5'd25: v = 15'd161;
			5'd26: v = 15'd128;
			5'd27: v = 15'd96;
			5'd28: v = 15'd64;
			5'd29: v = 15'd48;
			5'd30: v = 15'd32;
			5'd31: v = 15'd16;
			default: v = 15'd0;
		endcase
		return v;
	endfunction

	// pred + floor(((ref - pred) << shift + 32) / 64), clamped to 0..255
	function automatic logic [7:0] blend_pixel(input logic [7:0] pred,
		input logic [7:0] refv, input logic [2:0] shift);
		logic signed [15:0] diff;
		logic signed [15:0] t;
		logic signed [15:0] adj;
		logic signed [15:0] v;
		logic [7:0]         res;
		diff = $signed({8'd0, refv}) - $signed({8'd0, pred});
		t    = (diff <<< shift) + 16'sd32;
		adj  = t >>> 6;
		v    = $signed({8'd0, pred}) + adj;
		if (v < 16'sd0) begin
			res = 8'd0;
		end else if (v > 16'sd255) begin
			res = 8'd255;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

### rtl/pdpc_ref_bank.sv
// One bank of the reference sample store: one write port, one registered read port.
`default_nettype none
module pdpc_ref_bank
	import pdpc_pkg::*;
#(
	parameter int ROWS = REF_DEPTH_DEF / NBANK,
	localparam int RW  = $clog2(ROWS)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [RW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [RW-1:0] raddr,
	output logic      [7:0]    rdata_q
);

	logic [7:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/pdpc_row_ctrl.sv
// Row counter, inverse-angle accumulator and per-bank reference addressing.
`default_nettype none
module pdpc_row_ctrl
	import pdpc_pkg::*;
#(
	parameter int REF_DEPTH = REF_DEPTH_DEF,
	localparam int AW = $clog2(REF_DEPTH),
	localparam int RW = AW - 3
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [4:0]                  angle_mode,
	input  wire logic [1:0]                  angular_scale,
	input  wire logic [6:0]                  block_height,
	output ctrl_t                            ctrl,
	output logic      [NBANK-1:0][RW-1:0]    bank_row
);

	logic [5:0]  row_q;
	logic [17:0] sum_q;

	logic [1:0]  scale;
	logic [6:0]  h;
	logic [6:0]  lim;
	logic [6:0]  wt;
	logic [14:0] inv;
	logic [17:0] sum_cur;
	logic [17:0] sum_nxt;
	logic [5:0]  row_nxt;
	logic [13:0] base_r;
	logic [AW:0] a0;

	always_comb begin
		scale = (angular_scale == 2'd3) ? 2'd2 : angular_scale;
		if (block_height == 7'd0) begin
			h = 7'd1;
		end else if (block_height > 7'd64) begin
			h = 7'd64;
		end else begin
			h = block_height;
		end
		lim = 7'd3 << scale;
		if (lim > h) begin
			lim = h;
		end
		wt  = {row_q, 1'b0} >> scale;
		inv = inv_angle(angle_mode);
		sum_cur = (row_q == 6'd0) ? (18'd256 + 18'(inv)) : sum_q;
		sum_nxt = sum_cur + 18'(inv);

		ctrl.corr  = {1'b0, row_q} < lim;
		ctrl.shift = 3'(7'd5 - wt);
		ctrl.last  = ({1'b0, row_q} + 7'd1) >= h;
		row_nxt    = ctrl.last ? 6'd0 : row_q + 6'd1;

		// base modulo depth by restoring steps; base < 16 * depth
		base_r = 14'(sum_cur[17:9]);
		for (int j = 3; j >= 0; j--) begin
			if (base_r >= 14'(REF_DEPTH << j)) begin
				base_r = base_r - 14'(REF_DEPTH << j);
			end
		end
		a0       = (AW+1)'(base_r[AW-1:0]) + (AW+1)'(1);
		ctrl.rot = a0[2:0];
	end

	for (genvar b = 0; b < NBANK; b++) begin : g_addr
		logic [2:0]  kb;
		logic [AW:0] ad;
		always_comb begin
			kb = 3'(b) - a0[2:0];
			ad = a0 + (AW+1)'(kb);
			if (ad >= (AW+1)'(REF_DEPTH)) begin
				ad = ad - (AW+1)'(REF_DEPTH);
			end
			bank_row[b] = ad[AW-1:3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			sum_q <= '0;
		end else if (step) begin
			row_q <= row_nxt;
			sum_q <= sum_nxt;
		end
	end

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		step && ctrl.last |=> row_q == 6'd0)
		else $error("row counter did not wrap after last row");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(row_q) && $stable(sum_q))
		else $error("row state moved without a row word");

endmodule
`default_nettype wire

### rtl/angular_pdpc_row_blend.sv
// Top level: config registers, reference store banks, read stage and blend output stage.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | mode, ref_address, ref_value, pixel_in_0..7
//  out     | out_valid/out_ready  | pixel_out_0..7, last_row
//
// A row word reads the banked store at acceptance into the read stage, and its blended result is
// registered in the output stage; one word per cycle is taken unless a stalled output fills both stages.
// Reference words below the store depth write the store at acceptance and produce no output word.
// Reset clears the row counter, angle sum and valid flags, sets config defaults; the store is not cleared.
// A stalled output holds the read stage; in_ready drops only when both stages are full.
`default_nettype none
module angular_pdpc_row_blend
	import pdpc_pkg::*;
#(
	parameter int REF_DEPTH = REF_DEPTH_DEF,
	parameter int LANES     = LANES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       mode,
	input  wire logic [8:0] ref_address,
	input  wire logic [7:0] ref_value,
	input  wire logic [7:0] pixel_in_0,
	input  wire logic [7:0] pixel_in_1,
	input  wire logic [7:0] pixel_in_2,
	input  wire logic [7:0] pixel_in_3,
	input  wire logic [7:0] pixel_in_4,
	input  wire logic [7:0] pixel_in_5,
	input  wire logic [7:0] pixel_in_6,
	input  wire logic [7:0] pixel_in_7,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      pixel_out_0,
	output logic [7:0]      pixel_out_1,
	output logic [7:0]      pixel_out_2,
	output logic [7:0]      pixel_out_3,
	output logic [7:0]      pixel_out_4,
	output logic [7:0]      pixel_out_5,
	output logic [7:0]      pixel_out_6,
	output logic [7:0]      pixel_out_7,
	output logic            last_row
);

	localparam int AW   = $clog2(REF_DEPTH);
	localparam int RW   = AW - 3;
	localparam int ROWS = REF_DEPTH / NBANK;

	logic [4:0] angle_q;
	logic [1:0] scale_q;
	logic [6:0] height_q;
	logic       wide_q;

	logic                     in_acc;
	logic                     load_s1;
	logic                     adv_s1;
	logic                     v_s1;
	logic [7:0][7:0]          pix_s1;
	ctrl_t                    ctrl_s1;
	logic [7:0]               en_s1;
	logic                     out_valid_q;
	logic [7:0][7:0]          pix_q;
	logic                     last_q;

	ctrl_t                    ctrl;
	logic [NBANK-1:0][RW-1:0] bank_row;
	logic [NBANK-1:0][7:0]    bank_rd;
	logic [7:0][7:0]          pix_in;
	logic [7:0]               lane_en;
	logic [7:0][7:0]          pix_blend;
	logic [10:0]              wa_ext;
	logic                     wa_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q  <= '0;
			scale_q  <= '0;
			height_q <= HEIGHT_RST;
			wide_q   <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ANGLE:  angle_q  <= cfg_data[4:0];
				CFG_SCALE:  scale_q  <= cfg_data[1:0];
				CFG_HEIGHT: height_q <= cfg_data[6:0];
				CFG_WIDE:   wide_q   <= cfg_data[0];
			endcase
		end
	end

	assign adv_s1   = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv_s1;
	assign in_acc   = in_valid && in_ready;
	assign load_s1  = in_acc && mode;

	assign pix_in = {pixel_in_7, pixel_in_6, pixel_in_5, pixel_in_4,
		pixel_in_3, pixel_in_2, pixel_in_1, pixel_in_0};

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			lane_en[k] = (k < LANES) && (wide_q || (k < 4));
		end
	end

	pdpc_row_ctrl #(
		.REF_DEPTH(REF_DEPTH)
	) u_row_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (load_s1),
		.angle_mode   (angle_q),
		.angular_scale(scale_q),
		.block_height (height_q),
		.ctrl         (ctrl),
		.bank_row     (bank_row)
	);

	assign wa_ext = 11'(ref_address);
	assign wa_ok  = wa_ext < 11'(REF_DEPTH);

	for (genvar b = 0; b < NBANK; b++) begin : g_bank
		pdpc_ref_bank #(
			.ROWS(ROWS)
		) u_bank (
			.clk    (clk),
			.we     (in_acc && !mode && wa_ok && (ref_address[2:0] == 3'(b))),
			.waddr  (wa_ext[AW-1:3]),
			.wdata  (ref_value),
			.re     (load_s1),
			.raddr  (bank_row[b]),
			.rdata_q(bank_rd[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load_s1) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			pix_s1  <= pix_in;
			ctrl_s1 <= ctrl;
			en_s1   <= lane_en;
		end
	end

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			pix_blend[k] = (ctrl_s1.corr && en_s1[k])
				? blend_pixel(pix_s1[k], bank_rd[3'(ctrl_s1.rot + 3'(k))], ctrl_s1.shift)
				: pix_s1[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pix_q  <= pix_blend;
			last_q <= ctrl_s1.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_out_0 = pix_q[0];
	assign pixel_out_1 = pix_q[1];
	assign pixel_out_2 = pix_q[2];
	assign pixel_out_3 = pix_q[3];
	assign pixel_out_4 = pix_q[4];
	assign pixel_out_5 = pix_q[5];
	assign pixel_out_6 = pix_q[6];
	assign pixel_out_7 = pix_q[7];
	assign last_row    = last_q;

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && out_valid_q)
		else $error("input stalled with a free stage");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && out_valid_q && !out_ready |=> v_s1 && $stable(pix_s1) && $stable(bank_rd))
		else $error("read stage lost its word under stall");

	a_row_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode |=> v_s1)
		else $error("row word not captured");

endmodule
`default_nettype wire
